### sv/itp_pkg.sv
// shared types, character codes and helper functions for the infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CHAR_W      = 8;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int PREC_W      = 2;

    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP
    } t_stk_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // precedence: operators rank from 1 to 3, any other character maps to zero
    function automatic logic [PREC_W-1:0] prec_of(input logic [CHAR_W-1:0] c);
        logic [PREC_W-1:0] p;
        if (c == CH_CARET) begin
            p = 2'd3;
        end else if (c inside {CH_STAR, CH_SLASH}) begin
            p = 2'd2;
        end else if (c inside {CH_PLUS, CH_MINUS}) begin
            p = 2'd1;
        end else begin
            p = 2'd0;
        end
        return p;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    endfunction

endpackage

`default_nettype wire

### sv/itp_cell.sv
// one entry of the shifting operator stack
`timescale 1ns / 1ps
`default_nettype none

module itp_cell (
    input  wire logic                      i_clk,
    input  wire itp_pkg::t_stk_op          i_op,
    input  wire logic [itp_pkg::CHAR_W-1:0] i_above,
    input  wire logic [itp_pkg::CHAR_W-1:0] i_below,
    output logic      [itp_pkg::CHAR_W-1:0] o_entry
);
    import itp_pkg::*;

    logic [CHAR_W-1:0] r_entry;
    logic [CHAR_W-1:0] n_entry;

    always_comb begin
        case (i_op)
            STK_PUSH: n_entry = i_above;
            STK_POP:  n_entry = i_below;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

### sv/infix_to_postfix_converter.sv
// top level: sequencer, stack of shifting cells and output register
`timescale 1ns / 1ps
`default_nettype none

// Converts an infix expression, one ASCII character per input beat, into postfix
// output beats using an operator stack of 32 entries built as a row of shifting
// cells (cell 0 is the top). One item is handled at a time: a letter goes straight
// out, '(' is pushed, an operator first pops entries of equal or higher precedence
// and is then pushed, ')' pops down to its bracket and drops it, and an item marked
// end_of_expr then flushes what is left. Each popped entry but a dropped bracket
// leaves through the output register, and a stalled output holds the sequencer.
// run_last marks the final output beat of an item, and stack_overflow stays set on
// every output beat from a dropped push until the end of that expression.
module infix_to_postfix_converter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [itp_pkg::CHAR_W-1:0] i_char_in,
    input  wire logic                       i_end_of_expr,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [itp_pkg::CHAR_W-1:0] o_char_out,
    output logic                            o_run_last,
    output logic                            o_stack_overflow
);
    import itp_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic               r_ovf;
    logic               n_ovf;
    logic [CHAR_W-1:0]  r_char;
    logic               r_end;

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic               r_out_ovf;

    t_stk_op            stk_op;
    logic [CHAR_W-1:0]  entry [STACK_DEPTH];
    logic [CHAR_W-1:0]  top0;
    logic [CHAR_W-1:0]  top1;

    logic               accept;
    logic               can_emit;
    logic               emit;
    logic [CHAR_W-1:0]  emit_char;
    logic               emit_last;
    logic [PREC_W-1:0]  prec_in;
    logic               op_pop;
    logic               op_cont;
    logic               rp_pop;
    logic               rp_cont;
    logic               full;
    logic               above_one;
    logic               above_two;

    // row of stack cells
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [CHAR_W-1:0] above;
        logic [CHAR_W-1:0] below;
        if (k == 0) begin : g_first
            assign above = r_char;
        end else begin : g_mid
            assign above = entry[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_last
            assign below = entry[k];
        end else begin : g_inner
            assign below = entry[k+1];
        end
        itp_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (stk_op),
            .i_above (above),
            .i_below (below),
            .o_entry (entry[k])
        );
    end

    assign top0      = entry[0];
    assign top1      = entry[1];
    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;
    assign can_emit  = !r_out_valid || i_ready;
    assign full      = (r_level == LEVEL_W'(STACK_DEPTH));
    assign above_one = (r_level > LEVEL_W'(1));
    assign above_two = (r_level > LEVEL_W'(2));
    assign prec_in   = prec_of(r_char);
    assign op_pop    = (r_level != '0) && (prec_in <= prec_of(top0));
    assign op_cont   = above_one && (prec_in <= prec_of(top1));
    assign rp_pop    = (r_level != '0) && (top0 != CH_RPAREN ? top0 != CH_LPAREN : 1'b1);
    assign rp_cont   = above_one && (top1 != CH_LPAREN);

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_ovf     = r_ovf;
        stk_op    = STK_HOLD;
        emit      = 1'b0;
        emit_char = top0;
        emit_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (is_letter(r_char)) begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_char = r_char;
                        emit_last = !(r_end && (r_level != '0));
                        if (r_end && (r_level != '0)) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_IDLE;
                            if (r_end) begin
                                n_ovf = 1'b0;
                            end
                        end
                    end
                end else if (r_char == CH_LPAREN) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        stk_op  = STK_PUSH;
                        n_level = r_level + LEVEL_W'(1);
                    end
                    n_state = r_end ? ST_FLUSH : ST_IDLE;
                end else if (r_char == CH_RPAREN) begin
                    if (rp_pop) begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            emit_last = !rp_cont && !(r_end && above_two);
                            stk_op    = STK_POP;
                            n_level   = r_level - LEVEL_W'(1);
                        end
                    end else begin
                        // drop the matching bracket, if any
                        if (r_level != '0) begin
                            stk_op  = STK_POP;
                            n_level = r_level - LEVEL_W'(1);
                        end
                        if (r_end && above_one) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_IDLE;
                            if (r_end) begin
                                n_ovf = 1'b0;
                            end
                        end
                    end
                end else begin
                    if (op_pop) begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            emit_last = !op_cont && !r_end;
                            stk_op    = STK_POP;
                            n_level   = r_level - LEVEL_W'(1);
                        end
                    end else begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            stk_op  = STK_PUSH;
                            n_level = r_level + LEVEL_W'(1);
                        end
                        n_state = r_end ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_level == '0) begin
                    n_state = ST_IDLE;
                    n_ovf   = 1'b0;
                end else if (can_emit) begin
                    emit      = 1'b1;
                    emit_last = !above_one;
                    stk_op    = STK_POP;
                    n_level   = r_level - LEVEL_W'(1);
                    if (!above_one) begin
                        n_state = ST_IDLE;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_level <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char_in;
            r_end  <= i_end_of_expr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_char_out       = r_out_char;
    assign o_run_last       = r_out_last;
    assign o_stack_overflow = r_out_ovf;

endmodule

`default_nettype wire

### sv/itp_checker.sv
// port-level assertions for the infix to postfix converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module itp_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic [itp_pkg::CHAR_W-1:0] o_char_out,
    input wire logic                       o_run_last,
    input wire logic                       o_stack_overflow
);

    // reset empties the output and reopens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output beat or busy input after reset");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_out)
            && $stable(o_run_last) && $stable(o_stack_overflow))
        else $error("stalled output beat changed");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while an item is in work");

    // overflow flag stays up within the beats of one item
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_stack_overflow && !o_run_last
            |=> !o_valid || o_stack_overflow)
        else $error("overflow flag dropped inside an item");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

`default_nettype wire

### verif/infix_to_postfix_converter_test.sv
// self-checking testbench for the infix to postfix converter
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;
    import itp_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              eoe;
    } t_infix_char;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } t_postfix_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_char_in = '0;
    logic              i_end_of_expr = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [CHAR_W-1:0] o_char_out;
    logic              o_run_last;
    logic              o_stack_overflow;

    t_infix_char   infix_q[$];
    t_postfix_beat postfix_q[$];

    // shadow of the operator stack
    logic [CHAR_W-1:0] op_stack[STACK_DEPTH];
    int                op_level = 0;
    logic              ovf_sticky = 1'b0;

    int items_taken = 0;
    int mismatches = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_wait = 0;
    int rx_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    infix_to_postfix_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_in        (i_char_in),
        .i_end_of_expr    (i_end_of_expr),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_char_out       (o_char_out),
        .o_run_last       (o_run_last),
        .o_stack_overflow (o_stack_overflow)
    );

    always #1 i_clk = ~i_clk;

    function automatic int rank_of(input logic [CHAR_W-1:0] c);
        int r;
        if (c == CH_CARET) begin
            r = 3;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            r = 2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r = 1;
        end else begin
            r = -1;
        end
        return r;
    endfunction

    // shunting-yard step on the shadow stack, queues the postfix beats it yields
    task automatic convert_char(input logic [CHAR_W-1:0] c, input logic last);
        logic [CHAR_W-1:0] emitted[$];
        t_postfix_beat     b;
        int                r;
        if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
            emitted.push_back(c);
        end else if (c == CH_RPAREN) begin
            while (op_level > 0 && op_stack[op_level-1] != CH_LPAREN) begin
                op_level--;
                emitted.push_back(op_stack[op_level]);
            end
            if (op_level > 0) begin
                op_level--;
            end
        end else begin
            if (c != CH_LPAREN) begin
                r = rank_of(c);
                while (op_level > 0 && r <= rank_of(op_stack[op_level-1])) begin
                    op_level--;
                    emitted.push_back(op_stack[op_level]);
                end
            end
            if (op_level < STACK_DEPTH) begin
                op_stack[op_level] = c;
                op_level++;
            end else begin
                ovf_sticky = 1'b1;
            end
        end
        if (last) begin
            while (op_level > 0 && emitted.size() < STACK_DEPTH + 1) begin
                op_level--;
                emitted.push_back(op_stack[op_level]);
            end
        end
        foreach (emitted[k]) begin
            b.ch   = emitted[k];
            b.last = (k == emitted.size() - 1);
            b.ovf  = ovf_sticky;
            postfix_q.push_back(b);
        end
        if (last) begin
            ovf_sticky = 1'b0;
        end
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 1) == 0) begin
            c = CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
        end else begin
            c = CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_op();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 4))
            0: c = CH_CARET;
            1: c = CH_STAR;
            2: c = CH_SLASH;
            3: c = CH_PLUS;
            default: c = CH_MINUS;
        endcase
        return c;
    endfunction

    task automatic add_char(input logic [CHAR_W-1:0] c, input logic eoe);
        t_infix_char it;
        it.ch  = c;
        it.eoe = eoe;
        infix_q.push_back(it);
    endtask

    // driver: presents queued characters, random gaps between beats
    always @(posedge i_clk) begin
        t_infix_char nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && o_ready) begin
                convert_char(i_char_in, i_end_of_expr);
                items_taken <= items_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (infix_q.size() > 0) begin
                    nxt = infix_q.pop_front();
                    i_valid       <= 1'b1;
                    i_char_in     <= nxt.ch;
                    i_end_of_expr <= nxt.eoe;
                    if (tx_calm > 0) begin
                        tx_calm <= tx_calm - 1;
                        tx_gap  <= 0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        tx_calm <= $urandom_range(10, 30);
                        tx_gap  <= 0;
                    end else begin
                        tx_gap <= $urandom_range(0, 13);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output beat, random back-pressure and one long hold
    always @(posedge i_clk) begin
        t_postfix_beat want;
        int            w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            w = rx_wait;
            if (o_valid && i_ready) begin
                if (postfix_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none got char %h last %b ovf %b",
                             $time, o_char_out, o_run_last, o_stack_overflow);
                    mismatches++;
                end else begin
                    want = postfix_q.pop_front();
                    if (o_char_out !== want.ch) begin
                        $display("%0t: char_out expected %h got %h", $time, want.ch, o_char_out);
                        mismatches++;
                    end
                    if (o_run_last !== want.last) begin
                        $display("%0t: run_last expected %b got %b", $time, want.last,
                                 o_run_last);
                        mismatches++;
                    end
                    if (o_stack_overflow !== want.ovf) begin
                        $display("%0t: stack_overflow expected %b got %b", $time, want.ovf,
                                 o_stack_overflow);
                        mismatches++;
                    end
                end
                if (rx_calm > 0) begin
                    rx_calm--;
                    w = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_calm = $urandom_range(10, 40);
                    w = 0;
                end else begin
                    w = $urandom_range(0, 13);
                end
            end else if (w > 0) begin
                w--;
            end
            if (!hold_done && items_taken >= 120) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
            end
            rx_wait <= w;
            i_ready <= (w == 0) && (hold_left == 0);
        end
    end

    initial begin
        int n;
        int depth;
        int start;
        int kind;
        int grp;

        // directed: every operator, caret grouping, parentheses
        add_char("A", 1'b0);
        add_char(CH_PLUS, 1'b0);
        add_char("z", 1'b0);
        add_char(CH_CARET, 1'b0);
        add_char("Z", 1'b0);
        add_char(CH_CARET, 1'b0);
        add_char("a", 1'b0);
        add_char(CH_STAR, 1'b0);
        add_char("B", 1'b0);
        add_char(CH_SLASH, 1'b0);
        add_char("C", 1'b0);
        add_char(CH_MINUS, 1'b0);
        add_char(CH_LPAREN, 1'b0);
        add_char("D", 1'b0);
        add_char(CH_RPAREN, 1'b0);
        add_char("E", 1'b1);
        // unmatched closing bracket, empty then non-empty stack
        add_char(CH_RPAREN, 1'b1);
        add_char("b", 1'b0);
        add_char(CH_MINUS, 1'b0);
        add_char(CH_RPAREN, 1'b1);
        // codes around the letter ranges and the byte extremes
        add_char(8'h00, 1'b0);
        add_char(8'h40, 1'b0);
        add_char(8'h5B, 1'b0);
        add_char(8'h60, 1'b0);
        add_char(8'h7B, 1'b0);
        add_char(8'hFF, 1'b1);

        grp = 0;
        while (infix_q.size() < 430) begin
            kind = (grp == 0) ? 6 : $urandom_range(0, 9);
            grp++;
            start = infix_q.size();
            if (kind <= 5 || kind == 9) begin
                // well-formed expression, optionally with one character corrupted
                n = $urandom_range(1, 6);
                depth = 0;
                for (int k = 0; k < n; k++) begin
                    while (depth < 4 && $urandom_range(0, 3) == 0) begin
                        add_char(CH_LPAREN, 1'b0);
                        depth++;
                    end
                    add_char(rand_letter(), 1'b0);
                    while (depth > 0 && $urandom_range(0, 2) == 0) begin
                        add_char(CH_RPAREN, 1'b0);
                        depth--;
                    end
                    if (k < n - 1) begin
                        add_char(rand_op(), 1'b0);
                    end
                end
                while (depth > 0) begin
                    add_char(CH_RPAREN, 1'b0);
                    depth--;
                end
                if (kind == 9) begin
                    infix_q[$urandom_range(start, infix_q.size() - 1)].ch =
                        CHAR_W'($urandom_range(0, 255));
                end
            end else if (kind <= 7) begin
                // deep nesting that can run past the stack depth
                n = $urandom_range(24, 40);
                for (int k = 0; k < n; k++) begin
                    add_char(CH_LPAREN, 1'b0);
                    if ($urandom_range(0, 1) == 0) begin
                        add_char(rand_letter(), 1'b0);
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        add_char(rand_op(), 1'b0);
                    end
                end
                add_char(rand_letter(), 1'b0);
            end else begin
                n = $urandom_range(3, 12);
                for (int k = 0; k < n; k++) begin
                    add_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
            infix_q[infix_q.size() - 1].eoe = 1'b1;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (infix_q.size() != 0 || i_valid);
        do @(posedge i_clk); while (postfix_q.size() != 0);
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && postfix_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
